[sv/alu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package alu_pkg;
  localparam int DataWidth = 32;
  localparam int ShWidth = $clog2(DataWidth);
  localparam int QueueDepth = 4;
  localparam int QueueAw = $clog2(QueueDepth);
  localparam int CntWidth = $clog2(DataWidth + 1);

  typedef enum logic [3:0] {
    CmdAdd, CmdSub, CmdMul, CmdUdiv, CmdSdiv, CmdUrem, CmdSrem,
    CmdShl, CmdLshr, CmdAshr, CmdAnd, CmdOr, CmdXor, CmdCmp
  } cmd_e;

  typedef enum logic [3:0] {
    PrEq, PrNe, PrUgt, PrUge, PrUlt, PrUle, PrSgt, PrSge, PrSlt, PrSle
  } pred_e;

  typedef enum logic {StIdle, StDiv} st_e;

  typedef struct packed {
    logic [3:0]           cmd;
    logic [3:0]           pred;
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
    logic                 is_div;
    logic                 div_signed;
    logic                 want_rem;
    logic                 b_zero;
  } item_t;
endpackage
`default_nettype wire

[sv/alu_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module alu_front (
  input  logic                           start_i,
  input  logic                           full_i,
  input  logic [3:0]                     cmd_i,
  input  logic [3:0]                     predicate_i,
  input  logic [alu_pkg::DataWidth-1:0]  left_operand_i,
  input  logic [alu_pkg::DataWidth-1:0]  right_operand_i,
  output logic                           push_o,
  output alu_pkg::item_t                 item_o
);
  import alu_pkg::*;

  // Accept a beat when the queue has room
  assign push_o = start_i & ~full_i;

  // Classify the command for the back end
  always_comb begin
    item_o = '0;
    item_o.cmd = cmd_i;
    item_o.pred = predicate_i;
    item_o.a = left_operand_i;
    item_o.b = right_operand_i;
    item_o.b_zero = (right_operand_i == '0);
    unique case (cmd_i)
      CmdUdiv: item_o.is_div = 1'b1;
      CmdSdiv: begin item_o.is_div = 1'b1; item_o.div_signed = 1'b1; end
      CmdUrem: begin item_o.is_div = 1'b1; item_o.want_rem = 1'b1; end
      CmdSrem: begin
        item_o.is_div = 1'b1; item_o.div_signed = 1'b1; item_o.want_rem = 1'b1;
      end
      default: item_o.is_div = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

[sv/alu_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module alu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  alu_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output alu_pkg::item_t item_o
);
  import alu_pkg::*;

  item_t              mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QueueAw:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QueueAw+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  // Advance pointers and count
  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QueueAw+1)'(push_i) - (QueueAw+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end
endmodule
`default_nettype wire

[sv/alu_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module alu_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  alu_pkg::item_t                item_i,
  output logic                          pop_o,
  output logic                          done_o,
  output logic [alu_pkg::DataWidth-1:0] result_value_o,
  output logic                          divide_by_zero_o
);
  import alu_pkg::*;
  localparam int W = DataWidth;

  st_e                st_q, st_d;
  logic [W-1:0]       rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic               neg_q, neg_d, rem_sel_q, rem_sel_d;
  logic               done_q, done_d, dz_q, dz_d;
  logic [W-1:0]       res_q, res_d;
  logic               start_div, last_step;
  logic [W-1:0]       fast_res, mag_a, mag_b, a, b;
  logic [ShWidth-1:0] sh;
  logic [W:0]         trial;
  logic [W:0]         shifted;
  logic               lt_s, lt_u;

  assign a = item_i.a;
  assign b = item_i.b;
  assign sh = b[ShWidth-1:0];
  assign lt_s = $signed(a) < $signed(b);
  assign lt_u = a < b;
  assign mag_a = (item_i.div_signed && a[W-1]) ? W'(-a) : a;
  assign mag_b = (item_i.div_signed && b[W-1]) ? W'(-b) : b;
  assign start_div = (st_q == StIdle) && !empty_i && item_i.is_div && !item_i.b_zero;
  assign last_step = (cnt_q == CntWidth'(1));

  // Evaluate the non-divide operations combinationally
  always_comb begin
    fast_res = '0;
    unique case (item_i.cmd)
      CmdAdd:  fast_res = a + b;
      CmdSub:  fast_res = a - b;
      CmdMul:  fast_res = W'(a * b);
      CmdShl:  fast_res = a << sh;
      CmdLshr: fast_res = a >> sh;
      CmdAshr: fast_res = W'($signed(a) >>> sh);
      CmdAnd:  fast_res = a & b;
      CmdOr:   fast_res = a | b;
      CmdXor:  fast_res = a ^ b;
      CmdCmp: begin
        unique case (item_i.pred)
          PrEq:    fast_res = W'(a == b);
          PrNe:    fast_res = W'(a != b);
          PrUgt:   fast_res = W'(b < a);
          PrUge:   fast_res = W'(!lt_u);
          PrUlt:   fast_res = W'(lt_u);
          PrUle:   fast_res = W'(!(b < a));
          PrSgt:   fast_res = W'($signed(b) < $signed(a));
          PrSge:   fast_res = W'(!lt_s);
          PrSlt:   fast_res = W'(lt_s);
          PrSle:   fast_res = W'(!($signed(b) < $signed(a)));
          default: fast_res = '0;
        endcase
      end
      default: fast_res = '0;
    endcase
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (start_div) st_d = StDiv;
      StDiv:  if (last_step) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // One restoring divide step
  assign shifted = {rem_q, quo_q[W-1]};
  assign trial = shifted - {1'b0, dvs_q};

  // Datapath and output controls
  always_comb begin
    pop_o = (st_q == StIdle) && !empty_i;
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    neg_d = neg_q; rem_sel_d = rem_sel_q;
    done_d = 1'b0; dz_d = 1'b0; res_d = res_q;
    if (start_div) begin
      rem_d = '0; quo_d = mag_a; dvs_d = mag_b; cnt_d = CntWidth'(W);
      rem_sel_d = item_i.want_rem;
      neg_d = item_i.div_signed &&
              (item_i.want_rem ? a[W-1] : (a[W-1] ^ b[W-1]));
    end else if (pop_o) begin
      done_d = 1'b1;
      dz_d = item_i.is_div;
      res_d = item_i.is_div ? '0 : fast_res;
    end else if (st_q == StDiv) begin
      cnt_d = cnt_q - 1'b1;
      if (!trial[W]) begin
        rem_d = trial[W-1:0]; quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0]; quo_d = {quo_q[W-2:0], 1'b0};
      end
      if (last_step) begin
        done_d = 1'b1;
        res_d = rem_sel_q ? rem_d : quo_d;
        if (neg_q) res_d = W'(-res_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; done_q <= 1'b0; dz_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; done_q <= done_d; dz_q <= dz_d;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d;
    neg_q <= neg_d; rem_sel_q <= rem_sel_d; res_q <= res_d;
  end

  assign done_o = done_q;
  assign divide_by_zero_o = dz_q;
  assign result_value_o = res_q;
endmodule
`default_nettype wire

[sv/int32_alu_with_compare.sv]
// A non-divide op on an empty queue goes through the queue entry, then the done register;
// divide and remainder with nonzero divisor also run the restoring divider in the back end.
// Throughput: one beat per cycle for non-divide ops while no divide runs; a divide holds
// the back end until done (bit-serial restoring divider), the 4-entry queue absorbs starts.
// Reset: asynchronous active low, empties the queue and drops pending results;
// the receiver cannot stall, each result shows for one cycle on done_o.
`timescale 1ns / 1ps
`default_nettype none
module int32_alu_with_compare (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [3:0]                    cmd_i,
  input  logic [3:0]                    predicate_i,
  input  logic [alu_pkg::DataWidth-1:0] left_operand_i,
  input  logic [alu_pkg::DataWidth-1:0] right_operand_i,
  output logic                          done_o,
  output logic [alu_pkg::DataWidth-1:0] result_value_o,
  output logic                          divide_by_zero_o
);
  import alu_pkg::*;

  logic  push, pop, full, empty;
  item_t in_item, head_item;

  assign busy = full;

  alu_front u_front (
    .start_i(start), .full_i(full), .cmd_i(cmd_i), .predicate_i(predicate_i),
    .left_operand_i(left_operand_i), .right_operand_i(right_operand_i),
    .push_o(push), .item_o(in_item)
  );

  alu_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .item_i(in_item),
    .pop_i(pop), .full_o(full), .empty_o(empty), .item_o(head_item)
  );

  alu_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .empty_i(empty), .item_i(head_item),
    .pop_o(pop), .done_o(done_o), .result_value_o(result_value_o),
    .divide_by_zero_o(divide_by_zero_o)
  );
endmodule
`default_nettype wire

[sv/alu_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module alu_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          done_o,
  input logic                          divide_by_zero_o,
  input logic [alu_pkg::DataWidth-1:0] result_value_o
);
  // Zero divisor gives a zero result
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && divide_by_zero_o) |-> (result_value_o == '0))
    else $error("divide by zero with nonzero result");

  // Flag only rides on a result beat
  a_dz_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    divide_by_zero_o |-> done_o)
    else $error("divide_by_zero without done");

  // No result right after reset
  a_rst_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !done_o)
    else $error("result straight out of reset");
endmodule

bind int32_alu_with_compare alu_checker u_alu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .done_o(done_o),
  .divide_by_zero_o(divide_by_zero_o), .result_value_o(result_value_o)
);
`default_nettype wire
